// ===== src/qmc_pkg.sv =====
// ----------------------------------------------------------------------------
// qmc_pkg
// Shared constants, codes and types of the quintet mean curvature unit.
// ----------------------------------------------------------------------------
package qmc_pkg;

  // geometry of one transaction
  localparam int DIMS        = 3;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_POINTS  = NUM_CORNERS + 1;
  localparam int CENTRE_IDX  = NUM_CORNERS;
  localparam int POINT_W     = 63;

  // corner slots in the order they travel
  localparam int C00 = 0;
  localparam int C20 = 1;
  localparam int C02 = 2;
  localparam int C22 = 3;

  // defaults of the top-level parameters
  localparam int COORD_BITS_DEF    = 21;
  localparam int FRACTION_BITS_DEF = 10;

  // result format: H in Q16.16, and 1/2 of the formula folded in
  localparam int H_W          = 32;
  localparam int H_FRAC_SHIFT = 15;
  localparam int QUOT_W       = H_W + 1;

  // configuration port
  localparam int BOX_W    = 20;
  localparam int NUM_REGS = 4;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = $clog2(4 * NUM_REGS);

  // implementation constants
  localparam int QUEUE_DEPTH = 2;
  localparam int MUL_CHUNK   = 24;

  typedef enum logic [1:0] {
    REG_PERIODIC = 2'd0,
    REG_BOX_X    = 2'd1,
    REG_BOX_Y    = 2'd2,
    REG_BOX_Z    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_ZERO  = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic                       periodic_enable;
    logic [DIMS-1:0][BOX_W-1:0] box;
  } cfg_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } div_tag_t;

  typedef struct packed {
    logic signed [H_W-1:0] h;
    logic [1:0]            status;
  } res_t;

endpackage

// ===== src/qmc_in_if.sv =====
// ----------------------------------------------------------------------------
// qmc_in_if
// Input channel: one quintet of packed points per transaction.
// ----------------------------------------------------------------------------
interface qmc_in_if import qmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POINT_W-1:0] corner_00;
  logic [POINT_W-1:0] corner_20;
  logic [POINT_W-1:0] corner_02;
  logic [POINT_W-1:0] corner_22;
  logic [POINT_W-1:0] centre_point;

  modport source (output valid, corner_00, corner_20, corner_02, corner_22, centre_point,
                  input ready);
  modport sink   (input valid, corner_00, corner_20, corner_02, corner_22, centre_point,
                  output ready);
endinterface

// ===== src/qmc_out_if.sv =====
// ----------------------------------------------------------------------------
// qmc_out_if
// Result channel: mean curvature and status per transaction.
// ----------------------------------------------------------------------------
interface qmc_out_if import qmc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] mean_curvature;
  logic [1:0]            status;

  modport source (output valid, mean_curvature, status, input ready);
  modport sink   (input valid, mean_curvature, status, output ready);
endinterface

// ===== src/qmc_front.sv =====
// ----------------------------------------------------------------------------
// qmc_front
// Accepts quintets, forms corner-minus-centre vectors and applies the
// periodic wrap, then hands them to the queue.
// ----------------------------------------------------------------------------
module qmc_front import qmc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [POINT_W-1:0]                             pt_i [NUM_POINTS],
  input  cfg_t                                           cfg,
  input  logic                                           q_full,
  output logic                                           q_push,
  output logic [NUM_CORNERS*DIMS*(COORD_BITS+2)-1:0]     q_data
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 2;
  localparam int XW = (CB + 4 > BOX_W + 2) ? CB + 4 : BOX_W + 2;
  localparam int QW = NUM_CORNERS * DIMS * DW;

  logic          f_valid_r;
  logic [QW-1:0] b_r;
  logic [QW-1:0] b_nxt;
  logic signed [XW-1:0] d_w   [NUM_CORNERS][DIMS];
  logic signed [XW-1:0] box_w [DIMS];
  logic signed [XW-1:0] w_w   [NUM_CORNERS][DIMS];

  // difference and single minimum-image wrap per component
  always_comb begin
    b_nxt = '0;
    for (int i = 0; i < DIMS; i++) begin
      box_w[i] = XW'($signed({1'b0, cfg.box[i]}));
      for (int c = 0; c < NUM_CORNERS; c++) begin
        d_w[c][i] = XW'($signed(pt_i[c][i*CB +: CB]))
                  - XW'($signed(pt_i[CENTRE_IDX][i*CB +: CB]));
        priority if (cfg.periodic_enable && ((d_w[c][i] <<< 1) > box_w[i])) begin
          w_w[c][i] = d_w[c][i] - box_w[i];
        end else if (cfg.periodic_enable && ((d_w[c][i] <<< 1) < -box_w[i])) begin
          w_w[c][i] = d_w[c][i] + box_w[i];
        end else begin
          w_w[c][i] = d_w[c][i];
        end
        b_nxt[(c*DIMS+i)*DW +: DW] = w_w[c][i][DW-1:0];
      end
    end
  end

  // hold one vector set until the queue takes it
  assign in_ready = !f_valid_r || !q_full;
  assign q_push   = f_valid_r && !q_full;
  assign q_data   = b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid_r <= 1'b1;
    end else if (q_push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_r <= b_nxt;
    end
  end

endmodule

// ===== src/qmc_queue.sv =====
// ----------------------------------------------------------------------------
// qmc_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module qmc_queue import qmc_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         nonempty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign dout     = mem_r[rd_ptr_r];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== src/qmc_wmul.sv =====
// ----------------------------------------------------------------------------
// qmc_wmul
// Two-stage signed multiplier for wide operands: partial products of
// narrow chunks, then one shifted sum.
// ----------------------------------------------------------------------------
module qmc_wmul import qmc_pkg::*; #(
  parameter int AW = 25,
  parameter int BW = 25
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  localparam int CW   = MUL_CHUNK;
  localparam int NA   = (AW + CW - 1) / CW;
  localparam int NB   = (BW + CW - 1) / CW;
  localparam int AEW  = NA * CW;
  localparam int BEW  = NB * CW;
  localparam int PPW  = 2 * CW + 2;
  localparam int ACCW = (NA + NB) * CW + 2;

  logic [AEW-1:0]        ae;
  logic [BEW-1:0]        be;
  logic signed [CW:0]    ac [NA];
  logic signed [CW:0]    bc [NB];
  logic signed [PPW-1:0] pp_r [NA][NB];
  logic signed [ACCW-1:0] acc;
  logic signed [AW+BW-1:0] p_r;

  assign ae = AEW'(a);
  assign be = BEW'(b);

  // low chunks unsigned, top chunk carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        ac[i] = $signed({ae[i*CW+CW-1], ae[i*CW +: CW]});
      end else begin
        ac[i] = $signed({1'b0, ae[i*CW +: CW]});
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bc[j] = $signed({be[j*CW+CW-1], be[j*CW +: CW]});
      end else begin
        bc[j] = $signed({1'b0, be[j*CW +: CW]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  // align and add partial products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (ACCW'(pp_r[i][j]) <<< ((i + j) * CW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= $signed(acc[AW+BW-1:0]);
    end
  end

  assign p = p_r;

endmodule

// ===== src/qmc_div.sv =====
// ----------------------------------------------------------------------------
// qmc_div
// Pipelined restoring divider, one quotient bit per stage, for quotients
// known to be below 2^QB. Flags travel alongside.
// ----------------------------------------------------------------------------
module qmc_div import qmc_pkg::*; #(
  parameter int WW = 160,
  parameter int QB = QUOT_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WW-1:0] n_i,
  input  logic [WW-1:0] d_i,
  input  div_tag_t      tag_i,
  output logic [QB-1:0] q_o,
  output div_tag_t      tag_o
);

  logic [WW-1:0] rem_r [QB-1];
  logic [WW-1:0] dv_r  [QB-1];
  logic [QB-1:0] q_r   [QB];
  div_tag_t      tag_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [WW-1:0] rem_in, dv_in, dsh;
    logic [QB-1:0] q_in, q_nxt;
    div_tag_t      tag_in;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = n_i;
      assign dv_in  = d_i;
      assign q_in   = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign dv_in  = dv_r[s-1];
      assign q_in   = q_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    // trial subtract of the shifted divisor
    assign dsh = dv_in << K;
    assign ge  = (rem_in >= dsh);

    always_comb begin
      q_nxt    = q_in;
      q_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]   <= q_nxt;
        tag_r[s] <= tag_in;
      end
    end

    if (s < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? rem_in - dsh : rem_in;
          dv_r[s]  <= dv_in;
        end
      end
    end
  end

  assign q_o   = q_r[QB-1];
  assign tag_o = tag_r[QB-1];

endmodule

// ===== src/qmc_back.sv =====
// ----------------------------------------------------------------------------
// qmc_back
// Arithmetic pipeline: tangents, fundamental forms, normal, numerator and
// denominator, rounded division and saturation, then the output register.
// ----------------------------------------------------------------------------
module qmc_back import qmc_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       q_nonempty,
  input  logic [NUM_CORNERS*DIMS*(COORD_BITS+2)-1:0] q_data,
  output logic                                       q_pop,
  output res_t                                       res,
  output logic                                       res_valid,
  input  logic                                       res_ready
);

  localparam int DW   = COORD_BITS + 2;
  localparam int SW   = DW + 2;
  localparam int DDW  = DW + 1;
  localparam int PSW  = 2 * SW;
  localparam int EW   = PSW + 2;
  localparam int NPW  = 2 * DDW;
  localparam int NVW  = NPW + 1;
  localparam int NPRW = SW + NVW;
  localparam int NNW  = NPRW + 2;
  localparam int EGW  = EW + 1;
  localparam int NUMW = EGW + NNW + 1;
  localparam int DENW = 2 * EW + 1;
  localparam int SHN  = (FRACTION_BITS <= H_FRAC_SHIFT) ? H_FRAC_SHIFT - FRACTION_BITS : 0;
  localparam int SHD  = (FRACTION_BITS > H_FRAC_SHIFT) ? FRACTION_BITS - H_FRAC_SHIFT : 0;
  localparam int QB   = QUOT_W;
  localparam int NW   = ((NUMW + SHN > DENW + SHD) ? NUMW + SHN : DENW + SHD) + 2;
  localparam int DVW  = DENW + SHD + 1;
  localparam int WW   = ((NW > DVW + QB) ? NW : DVW + QB) + 1;
  localparam int PRE  = 11;
  localparam int LAT  = PRE + QB + 1;

  logic           en;
  logic [LAT-1:0] vld_r;

  // whole pipeline moves unless the result register is held
  assign en        = !vld_r[LAT-1] || res_ready;
  assign q_pop     = en && q_nonempty;
  assign res_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], q_nonempty};
    end
  end

  // stage 1: tangents, corner sums and normal differences
  logic signed [DW-1:0]  bv [NUM_CORNERS][DIMS];
  logic signed [SW-1:0]  s_r [DIMS], t_r [DIMS], sum4_1_r [DIMS], dif4_1_r [DIMS];
  logic signed [DDW-1:0] d21_r [DIMS], d03_r [DIMS];

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      for (int i = 0; i < DIMS; i++) begin
        bv[c][i] = $signed(q_data[(c*DIMS+i)*DW +: DW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIMS; i++) begin
        s_r[i]      <= SW'(bv[C22][i]) + SW'(bv[C20][i]) - SW'(bv[C02][i]) - SW'(bv[C00][i]);
        t_r[i]      <= SW'(bv[C22][i]) - SW'(bv[C20][i]) + SW'(bv[C02][i]) - SW'(bv[C00][i]);
        sum4_1_r[i] <= SW'(bv[C22][i]) + SW'(bv[C20][i]) + SW'(bv[C02][i]) + SW'(bv[C00][i]);
        dif4_1_r[i] <= SW'(bv[C22][i]) - SW'(bv[C20][i]) - SW'(bv[C02][i]) + SW'(bv[C00][i]);
        d21_r[i]    <= DDW'(bv[C02][i]) - DDW'(bv[C20][i]);
        d03_r[i]    <= DDW'(bv[C00][i]) - DDW'(bv[C22][i]);
      end
    end
  end

  // stages 2 and 3: products, form sums and normal
  logic signed [PSW-1:0] sss_r [DIMS], sst_r [DIMS], stt_r [DIMS];
  logic signed [NPW-1:0] nva_r [DIMS], nvb_r [DIMS];
  logic signed [SW-1:0]  sum4_2_r [DIMS], dif4_2_r [DIMS], sum4_3_r [DIMS], dif4_3_r [DIMS];
  logic signed [NVW-1:0] nv_r [DIMS];
  logic signed [EW-1:0]  e_nxt, f_nxt, g_nxt, e_3_r, f_3_r, g_3_r;

  for (genvar i = 0; i < DIMS; i++) begin : g_axis
    localparam int J = (i + 1) % DIMS;
    localparam int K = (i + 2) % DIMS;
    always_ff @(posedge clk) begin
      if (en) begin
        sss_r[i]    <= s_r[i] * s_r[i];
        sst_r[i]    <= s_r[i] * t_r[i];
        stt_r[i]    <= t_r[i] * t_r[i];
        nva_r[i]    <= d21_r[J] * d03_r[K];
        nvb_r[i]    <= d03_r[J] * d21_r[K];
        sum4_2_r[i] <= sum4_1_r[i];
        dif4_2_r[i] <= dif4_1_r[i];
        nv_r[i]     <= NVW'(nva_r[i]) - NVW'(nvb_r[i]);
        sum4_3_r[i] <= sum4_2_r[i];
        dif4_3_r[i] <= dif4_2_r[i];
      end
    end
  end

  always_comb begin
    e_nxt = '0;
    f_nxt = '0;
    g_nxt = '0;
    for (int i = 0; i < DIMS; i++) begin
      e_nxt = e_nxt + EW'(sss_r[i]);
      f_nxt = f_nxt + EW'(sst_r[i]);
      g_nxt = g_nxt + EW'(stt_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_3_r <= e_nxt;
      f_3_r <= f_nxt;
      g_3_r <= g_nxt;
    end
  end

  // stages 4 and 5: second-form products
  logic signed [NPRW-1:0] pn [DIMS], pm [DIMS];
  logic signed [EW-1:0]   e_4_r, f_4_r, g_4_r, e_5_r, f_5_r, g_5_r;

  for (genvar i = 0; i < DIMS; i++) begin : g_second
    qmc_wmul #(.AW(SW), .BW(NVW)) u_pn (
      .clk(clk), .en(en), .a(sum4_3_r[i]), .b(nv_r[i]), .p(pn[i])
    );
    qmc_wmul #(.AW(SW), .BW(NVW)) u_pm (
      .clk(clk), .en(en), .a(dif4_3_r[i]), .b(nv_r[i]), .p(pm[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_4_r <= e_3_r;
      f_4_r <= f_3_r;
      g_4_r <= g_3_r;
      e_5_r <= e_4_r;
      f_5_r <= f_4_r;
      g_5_r <= g_4_r;
    end
  end

  // stage 6: N, M and E + G
  logic signed [NNW-1:0] nn_nxt, mm_nxt, nn_r, mm_r;
  logic signed [EGW-1:0] eg_r;
  logic signed [EW-1:0]  e_6_r, f_6_r, g_6_r;

  always_comb begin
    nn_nxt = '0;
    mm_nxt = '0;
    for (int i = 0; i < DIMS; i++) begin
      nn_nxt = nn_nxt + NNW'(pn[i]);
      mm_nxt = mm_nxt + NNW'(pm[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r  <= nn_nxt;
      mm_r  <= mm_nxt;
      eg_r  <= EGW'(e_5_r) + EGW'(g_5_r);
      e_6_r <= e_5_r;
      f_6_r <= f_5_r;
      g_6_r <= g_5_r;
    end
  end

  // stages 7 and 8: numerator and denominator products
  logic signed [EGW+NNW-1:0] pa;
  logic signed [EW+NNW-1:0]  pb;
  logic signed [2*EW-1:0]    pc, pd;

  qmc_wmul #(.AW(EGW), .BW(NNW)) u_pa (.clk(clk), .en(en), .a(eg_r),  .b(nn_r),  .p(pa));
  qmc_wmul #(.AW(EW),  .BW(NNW)) u_pb (.clk(clk), .en(en), .a(f_6_r), .b(mm_r),  .p(pb));
  qmc_wmul #(.AW(EW),  .BW(EW))  u_pc (.clk(clk), .en(en), .a(e_6_r), .b(g_6_r), .p(pc));
  qmc_wmul #(.AW(EW),  .BW(EW))  u_pd (.clk(clk), .en(en), .a(f_6_r), .b(f_6_r), .p(pd));

  // stage 9: differences
  logic signed [NUMW-1:0] num_r;
  logic signed [DENW-1:0] den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NUMW'(pa) - NUMW'(pb);
      den_r <= DENW'(pc) - DENW'(pd);
    end
  end

  // stage 10: magnitudes, sign, zero test and rounding offset
  logic [NUMW-1:0] an;
  logic [DENW-1:0] ad;
  logic [WW-1:0]   n10_r, d10_r, n11_r, d11_r;
  div_tag_t        tag10_r, tag11_r, tag_o;
  logic [QB-1:0]   q_o;

  assign an = num_r[NUMW-1] ? NUMW'(-num_r) : NUMW'(num_r);
  assign ad = den_r[DENW-1] ? DENW'(-den_r) : DENW'(den_r);

  always_ff @(posedge clk) begin
    if (en) begin
      n10_r        <= (WW'(an) << (SHN + 1)) + (WW'(ad) << SHD);
      d10_r        <= WW'(ad) << (SHD + 1);
      tag10_r.neg  <= num_r[NUMW-1] ^ den_r[DENW-1];
      tag10_r.zero <= (den_r == '0);
      tag10_r.ovf  <= 1'b0;
    end
  end

  // stage 11: flag quotients too large for the divider
  always_ff @(posedge clk) begin
    if (en) begin
      n11_r        <= n10_r;
      d11_r        <= d10_r;
      tag11_r.neg  <= tag10_r.neg;
      tag11_r.zero <= tag10_r.zero;
      tag11_r.ovf  <= (n10_r >= (d10_r << QB));
    end
  end

  qmc_div #(.WW(WW), .QB(QB)) u_div (
    .clk(clk), .en(en),
    .n_i(n11_r), .d_i(d11_r), .tag_i(tag11_r),
    .q_o(q_o), .tag_o(tag_o)
  );

  // output register: sign, saturation and status
  logic [QB-1:0] lim;
  res_t          res_nxt, res_r;

  always_comb begin
    lim = tag_o.neg ? (QB'(1) << (H_W - 1)) : ((QB'(1) << (H_W - 1)) - QB'(1));
    priority if (tag_o.zero) begin
      res_nxt.h      = '0;
      res_nxt.status = ST_ZERO;
    end else if (tag_o.ovf || (q_o > lim)) begin
      res_nxt.h      = tag_o.neg ? $signed({1'b1, {(H_W-1){1'b0}}})
                                 : $signed({1'b0, {(H_W-1){1'b1}}});
      res_nxt.status = ST_SAT;
    end else begin
      res_nxt.h      = tag_o.neg ? $signed(-q_o[H_W-1:0]) : $signed(q_o[H_W-1:0]);
      res_nxt.status = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== src/quintet_mean_curvature_unit.sv =====
// ----------------------------------------------------------------------------
// quintet_mean_curvature_unit
// Mean curvature of a surface patch from a centre point and four corners.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : valid/ready channel, one quintet (four corners and the centre,
//            each three signed fixed-point coordinates) per transaction.
//   out_if : valid/ready channel, mean curvature in Q16.16 and a status
//            code (valid, zero denominator, saturated) per transaction.
//   APB    : psel/penable/pwrite/paddr/pwdata/prdata/pready, pready always
//            high; periodic enable at 0x0, box lengths x/y/z at 0x4/0x8/0xC.
//            Write the registers only while no transaction is in flight.
// Throughput: one transaction per cycle, sustained while out_if.ready stays high.
// Pipeline: the multiply stages come ahead of the radix-2 divider, one quotient
//   bit per stage over 33 stages.
// Reset: rst_n (synchronous, active low) empties the pipeline and queue and
//   clears the configuration registers to zero; data registers are not reset.
// Stall: when out_if.ready is low while a result is valid, the result is held
//   and the back pipeline stops; the front keeps accepting until the two-entry queue fills.
module quintet_mean_curvature_unit import qmc_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  qmc_in_if.sink            in_if,
  qmc_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int QW = NUM_CORNERS * DIMS * (COORD_BITS + 2);

  // configuration registers
  logic                 periodic_r;
  logic [BOX_W-1:0]     box_r [DIMS];
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  cfg_t                 cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periodic_r <= 1'b0;
      for (int i = 0; i < DIMS; i++) begin
        box_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PERIODIC: periodic_r <= pwdata[0];
        REG_BOX_X:    box_r[0]   <= pwdata[BOX_W-1:0];
        REG_BOX_Y:    box_r[1]   <= pwdata[BOX_W-1:0];
        REG_BOX_Z:    box_r[2]   <= pwdata[BOX_W-1:0];
        default:      ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_idx)
      REG_PERIODIC: prdata = APB_DW'(periodic_r);
      REG_BOX_X:    prdata = APB_DW'(box_r[0]);
      REG_BOX_Y:    prdata = APB_DW'(box_r[1]);
      REG_BOX_Z:    prdata = APB_DW'(box_r[2]);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg.periodic_enable = periodic_r;
    for (int i = 0; i < DIMS; i++) begin
      cfg.box[i] = box_r[i];
    end
  end

  // front, queue and back
  logic [POINT_W-1:0] pts [NUM_POINTS];
  logic               q_full, q_push, q_pop, q_nonempty;
  logic [QW-1:0]      q_din, q_dout;
  res_t               res;
  logic               res_valid;

  assign pts[C00]        = in_if.corner_00;
  assign pts[C20]        = in_if.corner_20;
  assign pts[C02]        = in_if.corner_02;
  assign pts[C22]        = in_if.corner_22;
  assign pts[CENTRE_IDX] = in_if.centre_point;

  qmc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .pt_i(pts), .cfg(cfg),
    .q_full(q_full), .q_push(q_push), .q_data(q_din)
  );

  qmc_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .nonempty(q_nonempty)
  );

  qmc_back #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_nonempty(q_nonempty), .q_data(q_dout), .q_pop(q_pop),
    .res(res), .res_valid(res_valid), .res_ready(out_if.ready)
  );

  assign out_if.valid          = res_valid;
  assign out_if.mean_curvature = res.h;
  assign out_if.status         = res.status;

  // a zero denominator always reports zero curvature
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status == ST_ZERO) |-> (out_if.mean_curvature == '0))
    else $error("zero-denominator result with nonzero curvature");

  // a saturated result sits at one of the two limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status == ST_SAT) |->
      ((out_if.mean_curvature == $signed({1'b1, {(H_W-1){1'b0}}})) ||
       (out_if.mean_curvature == $signed({1'b0, {(H_W-1){1'b1}}}))))
    else $error("saturated result not at a limit");

endmodule
